FILE: rtl/mpmm_pkg.sv
package mpmm_pkg;

  typedef enum logic [1:0] {
    ACT_WR_A  = 2'd0,
    ACT_WR_B  = 2'd1,
    ACT_CALC  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic kill;
  } tok_flags_t;

  localparam logic [63:0] MINUS_INF = 64'hFFDC_790D_903F_0000;

  localparam int IDX_BITS = 6;
  localparam int VAL_BITS = 64;

endpackage

FILE: rtl/mpmm_ram.sv
module mpmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mpmm_cell.sv
module mpmm_cell #(
  parameter int DIM = 64,
  parameter int IW  = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [63:0]           tok_a,
  input  logic [IW-1:0]         tok_k,
  input  logic [IW-1:0]         tok_i,
  input  mpmm_pkg::tok_flags_t  tok_f,
  output logic [63:0]           nxt_a,
  output logic [IW-1:0]         nxt_k,
  output logic [IW-1:0]         nxt_i,
  output mpmm_pkg::tok_flags_t  nxt_f,
  input  logic                  b_we,
  input  logic [IW-1:0]         b_waddr,
  input  logic [63:0]           b_wdata,
  input  logic                  c_re,
  input  logic [IW-1:0]         c_raddr,
  output logic [63:0]           c_rdata
);

  logic [63:0]          a_r;
  logic [IW-1:0]        k_r;
  logic [IW-1:0]        i_r;
  mpmm_pkg::tok_flags_t f_r;
  logic [63:0]          acc_r;
  logic [63:0]          acc_nxt;
  logic [63:0]          b_rd;
  logic [63:0]          sum;
  logic [63:0]          base;
  logic                 c_we;
  logic [63:0]          c_wdata;

  mpmm_ram #(.WIDTH(64), .DEPTH(DIM)) u_bcol (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(tok_f.valid), .raddr(tok_k), .rdata(b_rd)
  );

  always_comb begin
    sum     = a_r + b_rd;
    base    = f_r.first ? mpmm_pkg::MINUS_INF : acc_r;
    acc_nxt = ($signed(sum) > $signed(base)) ? sum : base;
    c_we    = f_r.valid && f_r.last;
    c_wdata = f_r.kill ? mpmm_pkg::MINUS_INF : acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r <= '0;
    end else begin
      f_r <= tok_f;
    end
    a_r <= tok_a;
    k_r <= tok_k;
    i_r <= tok_i;
    if (f_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  mpmm_ram #(.WIDTH(64), .DEPTH(DIM)) u_ccol (
    .clk(clk), .we(c_we), .waddr(i_r), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  assign nxt_a = a_r;
  assign nxt_k = k_r;
  assign nxt_i = i_r;
  assign nxt_f = f_r;

endmodule

FILE: rtl/max_plus_matrix_product.sv
// Writes of A or B are stored when the word is accepted; a read word passes through the C RAM and output registers.
// A compute word occupies the block while the sequencer feeds one A entry per cycle into
// the cell chain and then waits for the chain to drain.
// One word is taken per cycle when idle; a read blocks input until it reaches out.
// Reset (rst_n, synchronous) clears control and sets a_rows to 64; matrices are
// undefined until written.
module max_plus_matrix_product #(
  parameter int DIM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // row[5:0], col[11:6], value[75:12], zero fill
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // row_res[5:0], col_res[11:6], value_res[75:12], zero fill
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int IW  = $clog2(DIM);
  localparam int AAW = $clog2(DIM * DIM);
  localparam int RW  = $clog2(DIM + 1);
  localparam int DCW = $clog2(DIM + 3);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } seq_state_t;

  seq_state_t           state_r, state_nxt;
  logic [6:0]           a_rows_r;
  logic [RW-1:0]        rows_r, rows_nxt;
  logic [IW-1:0]        i_r, i_nxt, k_r, k_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic [IW-1:0]        hd_i_r, hd_k_r;
  mpmm_pkg::tok_flags_t hd_f_r, hd_f_nxt;

  logic                  acc_in;
  mpmm_pkg::action_t     act;
  logic [5:0]            f_row, f_col;
  logic [63:0]           f_val;
  logic                  idx_ok;
  logic [IW-1:0]         row_idx, col_idx;

  logic                  a_we;
  logic [AAW-1:0]        a_waddr, a_raddr;
  logic [63:0]           a_rd;

  logic                  rd_pend_r;
  logic [5:0]            rd_row_r, rd_col_r;
  logic                  rd_in_r;
  logic                  out_valid_r;
  logic [5:0]            out_row_r, out_col_r;
  logic [63:0]           out_val_r;
  logic                  out_load;

  logic [63:0]           ch_a [DIM];
  logic [IW-1:0]         ch_k [DIM];
  logic [IW-1:0]         ch_i [DIM];
  mpmm_pkg::tok_flags_t  ch_f [DIM];
  logic [63:0]           c_rd [DIM];

  assign act     = mpmm_pkg::action_t'(in_tuser);
  assign f_row   = in_tdata[5:0];
  assign f_col   = in_tdata[11:6];
  assign f_val   = in_tdata[75:12];
  assign idx_ok  = (int'(f_row) < DIM) && (int'(f_col) < DIM);
  assign row_idx = IW'(f_row);
  assign col_idx = IW'(f_col);

  assign in_tready = (state_r == S_IDLE) && !rd_pend_r;
  assign acc_in    = in_tvalid && in_tready;

  assign a_we    = acc_in && (act == mpmm_pkg::ACT_WR_A) && idx_ok;
  assign a_waddr = AAW'(int'(row_idx) * DIM + int'(col_idx));
  assign a_raddr = AAW'(int'(i_r) * DIM + int'(k_r));

  mpmm_ram #(.WIDTH(64), .DEPTH(DIM * DIM)) u_amem (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(f_val),
    .re(state_r == S_RUN), .raddr(a_raddr), .rdata(a_rd)
  );

  always_comb begin
    state_nxt = state_r;
    rows_nxt  = rows_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    dcnt_nxt  = dcnt_r;
    hd_f_nxt  = '0;
    case (state_r)
      S_IDLE: begin
        if (acc_in && act == mpmm_pkg::ACT_CALC) begin
          state_nxt = S_RUN;
          i_nxt     = '0;
          k_nxt     = '0;
          if (a_rows_r == 7'd0) begin
            rows_nxt = RW'(1);
          end else if (int'(a_rows_r) > DIM) begin
            rows_nxt = RW'(DIM);
          end else begin
            rows_nxt = RW'(a_rows_r);
          end
        end
      end
      S_RUN: begin
        hd_f_nxt.valid = 1'b1;
        hd_f_nxt.first = (k_r == '0);
        hd_f_nxt.last  = (k_r == IW'(DIM - 1));
        hd_f_nxt.kill  = (int'(i_r) >= int'(rows_r));
        if (k_r == IW'(DIM - 1)) begin
          k_nxt = '0;
          if (i_r == IW'(DIM - 1)) begin
            state_nxt = S_DRAIN;
            dcnt_nxt  = '0;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_DRAIN: begin
        if (dcnt_r == DCW'(DIM + 2)) begin
          state_nxt = S_IDLE;
        end else begin
          dcnt_nxt = dcnt_r + DCW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = rd_pend_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_rows_r    <= 7'd64;
      hd_f_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hd_f_r  <= hd_f_nxt;
      if (cfg_we) begin
        a_rows_r <= cfg_wdata;
      end
      if (acc_in && act == mpmm_pkg::ACT_READ) begin
        rd_pend_r <= 1'b1;
      end else if (out_load) begin
        rd_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    rows_r <= rows_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    dcnt_r <= dcnt_nxt;
    hd_i_r <= i_r;
    hd_k_r <= k_r;
    if (acc_in && act == mpmm_pkg::ACT_READ) begin
      rd_row_r <= f_row;
      rd_col_r <= f_col;
      rd_in_r  <= idx_ok;
    end
    if (out_load) begin
      out_row_r <= rd_row_r;
      out_col_r <= rd_col_r;
      out_val_r <= rd_in_r ? c_rd[IW'(rd_col_r)] : 64'd0;
    end
  end

  for (genvar j = 0; j < DIM; j++) begin : g_cell
    logic [63:0]          in_a;
    logic [IW-1:0]        in_k, in_i;
    mpmm_pkg::tok_flags_t in_f;
    logic                 bwe;

    if (j == 0) begin : g_head
      assign in_a = a_rd;
      assign in_k = hd_k_r;
      assign in_i = hd_i_r;
      assign in_f = hd_f_r;
    end else begin : g_link
      assign in_a = ch_a[j-1];
      assign in_k = ch_k[j-1];
      assign in_i = ch_i[j-1];
      assign in_f = ch_f[j-1];
    end

    assign bwe = acc_in && (act == mpmm_pkg::ACT_WR_B) && idx_ok && (int'(col_idx) == j);

    mpmm_cell #(.DIM(DIM), .IW(IW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .tok_a(in_a), .tok_k(in_k), .tok_i(in_i), .tok_f(in_f),
      .nxt_a(ch_a[j]), .nxt_k(ch_k[j]), .nxt_i(ch_i[j]), .nxt_f(ch_f[j]),
      .b_we(bwe), .b_waddr(row_idx), .b_wdata(f_val),
      .c_re(acc_in && act == mpmm_pkg::ACT_READ), .c_raddr(row_idx),
      .c_rdata(c_rd[j])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_val_r, out_col_r, out_row_r};

`ifndef ASSERT_OFF
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("input taken during compute");
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ch_f[DIM-1].valid) else $error("chain busy after drain");
  a_rd_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && !out_valid_r) |=> (!rd_pend_r && out_valid_r))
    else $error("read word not moved to output");
  a_run_feeds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |=> hd_f_r.valid) else $error("sequencer gap");
`endif

endmodule
